// ===== hw/rtl/mfrf_pkg.sv =====
`timescale 1ns / 1ps

package mfrf_pkg;

    localparam int DEFAULT_MAX_BITS = 32;

    localparam int FRAME_W = 32;
    localparam int COUNT_W = 6;
    localparam int TIMER_W = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] ACT_RX_TICK = 2'd0;
    localparam logic [1:0] ACT_LINE_EDGE = 2'd1;
    localparam logic [1:0] ACT_TX_TICK = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_HALF_BIT_THRESHOLD = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_TIMEOUT = 1'd1;

    localparam logic [TIMER_W-1:0] HALF_BIT_THRESHOLD_RESET = 8'd75;
    localparam logic [TIMER_W-1:0] FRAME_TIMEOUT_RESET = 8'd200;

    typedef struct packed {
        logic rx_tick;
        logic line_edge;
        logic tx_tick;
        logic level;
    } cmd_t;

endpackage

// ===== hw/rtl/mfrf_front.sv =====
`timescale 1ns / 1ps

module mfrf_front (
    input  logic             item_valid,
    output logic             item_ready,
    input  logic [1:0]       action,
    input  logic             line_level,
    input  logic             queue_full,
    output logic             push,
    output mfrf_pkg::cmd_t   push_cmd
);
    import mfrf_pkg::*;

    assign item_ready = !queue_full;
    assign push = item_valid && !queue_full;

    // An unused action code becomes a command that changes nothing.
    always_comb
    begin
        push_cmd = '0;
        push_cmd.level = line_level;
        case (action)
            ACT_RX_TICK:   push_cmd.rx_tick = 1'b1;
            ACT_LINE_EDGE: push_cmd.line_edge = 1'b1;
            ACT_TX_TICK:   push_cmd.tx_tick = 1'b1;
            default:       push_cmd = '0;
        endcase
    end

endmodule

// ===== hw/rtl/mfrf_queue.sv =====
`timescale 1ns / 1ps

module mfrf_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mfrf_pkg::cmd_t   push_cmd,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output mfrf_pkg::cmd_t   head_cmd
);
    import mfrf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_COUNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    cmd_t entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic do_pop;

    assign full = (count_reg == DEPTH_COUNT);
    assign valid = (count_reg != '0);
    assign head_cmd = entry_reg[rd_ptr_reg];
    assign do_pop = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hw/rtl/mfrf_back.sv =====
`timescale 1ns / 1ps

module mfrf_back #(
    parameter int MAX_BITS = mfrf_pkg::DEFAULT_MAX_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mfrf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mfrf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              cmd_valid,
    input  mfrf_pkg::cmd_t                    cmd,
    output logic                              cmd_pop,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic                              tx_line,
    output logic                              tx_busy,
    output logic                              frame_ended,
    output logic                              frame_forwarded,
    output logic [mfrf_pkg::COUNT_W-1:0]      frame_bits
);
    import mfrf_pkg::*;

    localparam int COUNT_CAP_INT = (MAX_BITS > 63) ? 63 : MAX_BITS;
    localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(COUNT_CAP_INT);

    logic [TIMER_W-1:0] threshold_reg;
    logic [TIMER_W-1:0] timeout_reg;

    logic               rx_running_reg, rx_running_next;
    logic [TIMER_W-1:0] rx_timer_reg, rx_timer_next;
    logic [FRAME_W-1:0] rx_shift_reg, rx_shift_next;
    logic [COUNT_W-1:0] rx_count_reg, rx_count_next;
    logic [FRAME_W-1:0] last_frame_reg, last_frame_next;
    logic [FRAME_W-1:0] tx_shift_reg, tx_shift_next;
    logic [COUNT_W-1:0] tx_bits_left_reg, tx_bits_left_next;
    logic               tx_phase_reg, tx_phase_next;
    logic               tx_active_reg, tx_active_next;
    logic               line_out_reg, line_out_next;

    logic               out_valid_reg;
    logic               ended_reg, ended_next;
    logic               forwarded_reg, forwarded_next;
    logic [COUNT_W-1:0] bits_reg, bits_next;

    logic [TIMER_W:0]   timer_inc;
    logic [COUNT_W-1:0] bit_index;
    logic               cur_bit;

    assign cfg_ready = 1'b1;
    assign cmd_pop = cmd_valid && (!out_valid_reg || result_ready);

    assign result_valid = out_valid_reg;
    assign tx_line = line_out_reg;
    assign tx_busy = tx_active_reg;
    assign frame_ended = ended_reg;
    assign frame_forwarded = forwarded_reg;
    assign frame_bits = bits_reg;

    assign timer_inc = {1'b0, rx_timer_reg} + 1'b1;
    assign bit_index = tx_bits_left_reg - 1'b1;
    // Bit positions beyond the frame register are sent as zero.
    assign cur_bit = bit_index[COUNT_W-1] ? 1'b0 : tx_shift_reg[bit_index[COUNT_W-2:0]];

    always_comb
    begin
        rx_running_next = rx_running_reg;
        rx_timer_next = rx_timer_reg;
        rx_shift_next = rx_shift_reg;
        rx_count_next = rx_count_reg;
        last_frame_next = last_frame_reg;
        tx_shift_next = tx_shift_reg;
        tx_bits_left_next = tx_bits_left_reg;
        tx_phase_next = tx_phase_reg;
        tx_active_next = tx_active_reg;
        line_out_next = line_out_reg;
        ended_next = 1'b0;
        forwarded_next = 1'b0;
        bits_next = '0;

        if (cmd.rx_tick)
        begin
            if (rx_running_reg)
            begin
                if (timer_inc >= {1'b0, timeout_reg})
                begin
                    rx_running_next = 1'b0;
                    rx_timer_next = '0;
                    ended_next = 1'b1;
                    bits_next = rx_count_reg;
                    if (rx_shift_reg != last_frame_reg)
                    begin
                        last_frame_next = rx_shift_reg;
                        tx_shift_next = rx_shift_reg;
                        tx_bits_left_next = rx_count_reg;
                        tx_phase_next = 1'b0;
                        tx_active_next = 1'b1;
                        forwarded_next = 1'b1;
                    end
                end
                else
                begin
                    rx_timer_next = timer_inc[TIMER_W-1:0];
                end
            end
        end
        else if (cmd.line_edge)
        begin
            if (!rx_running_reg)
            begin
                rx_running_next = 1'b1;
                rx_timer_next = '0;
                rx_shift_next = '0;
                rx_count_next = '0;
            end
            else if (!((rx_count_reg != '0) && (rx_timer_reg <= threshold_reg)))
            begin
                rx_timer_next = '0;
                rx_shift_next = {rx_shift_reg[FRAME_W-2:0], cmd.level};
                if (rx_count_reg < COUNT_CAP)
                begin
                    rx_count_next = rx_count_reg + 1'b1;
                end
            end
        end
        else if (cmd.tx_tick)
        begin
            if (tx_active_reg)
            begin
                if (tx_bits_left_reg == '0)
                begin
                    line_out_next = 1'b0;
                    tx_active_next = 1'b0;
                end
                else if (!tx_phase_reg)
                begin
                    line_out_next = cur_bit;
                    tx_phase_next = 1'b1;
                end
                else
                begin
                    line_out_next = !cur_bit;
                    tx_phase_next = 1'b0;
                    tx_bits_left_next = bit_index;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= HALF_BIT_THRESHOLD_RESET;
            timeout_reg <= FRAME_TIMEOUT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_HALF_BIT_THRESHOLD: threshold_reg <= cfg_data;
                REG_FRAME_TIMEOUT:      timeout_reg <= cfg_data;
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_running_reg <= 1'b0;
            rx_timer_reg <= '0;
            rx_shift_reg <= '0;
            rx_count_reg <= '0;
            last_frame_reg <= '0;
            tx_shift_reg <= '0;
            tx_bits_left_reg <= '0;
            tx_phase_reg <= 1'b0;
            tx_active_reg <= 1'b0;
            line_out_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_pop)
            begin
                rx_running_reg <= rx_running_next;
                rx_timer_reg <= rx_timer_next;
                rx_shift_reg <= rx_shift_next;
                rx_count_reg <= rx_count_next;
                last_frame_reg <= last_frame_next;
                tx_shift_reg <= tx_shift_next;
                tx_bits_left_reg <= tx_bits_left_next;
                tx_phase_reg <= tx_phase_next;
                tx_active_reg <= tx_active_next;
                line_out_reg <= line_out_next;
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            ended_reg <= ended_next;
            forwarded_reg <= forwarded_next;
            bits_reg <= bits_next;
        end
    end

endmodule

// ===== hw/rtl/manchester_frame_repeat_filter.sv =====
`timescale 1ns / 1ps

// Manchester frame repeat filter. Each item is a receive tick, a line edge with
// its sampled level, or a transmit half-bit tick, and each item yields exactly
// one result showing the transmit line, the transmitter state and whether a
// frame ended and was forwarded on that item. The block takes one item per
// clock while the command queue is not full. The item is written into the
// two-entry command queue at the accepting edge and then passes into the
// output register of the state update unit when that is free. Either
// side may stall without stopping the other until the queue fills. A
// configuration write is never stalled and takes effect at the edge that
// accepts it, so it should only be issued while no item is in flight.

module manchester_frame_repeat_filter #(
    parameter int MAX_BITS = mfrf_pkg::DEFAULT_MAX_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mfrf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mfrf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic [1:0]                        action,
    input  logic                              line_level,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic                              tx_line,
    output logic                              tx_busy,
    output logic                              frame_ended,
    output logic                              frame_forwarded,
    output logic [mfrf_pkg::COUNT_W-1:0]      frame_bits
);
    import mfrf_pkg::*;

    logic queue_full;
    logic push;
    cmd_t push_cmd;
    logic queue_valid;
    cmd_t head_cmd;
    logic cmd_pop;

    mfrf_front u_front (
        .item_valid (item_valid),
        .item_ready (item_ready),
        .action     (action),
        .line_level (line_level),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    mfrf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (cmd_pop),
        .valid    (queue_valid),
        .head_cmd (head_cmd)
    );

    mfrf_back #(
        .MAX_BITS (MAX_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd_valid       (queue_valid),
        .cmd             (head_cmd),
        .cmd_pop         (cmd_pop),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .tx_line         (tx_line),
        .tx_busy         (tx_busy),
        .frame_ended     (frame_ended),
        .frame_forwarded (frame_forwarded),
        .frame_bits      (frame_bits)
    );

endmodule

// ===== bench/manchester_frame_repeat_filter_tb.sv =====
`timescale 1ns / 1ps

module manchester_frame_repeat_filter_tb;

    import mfrf_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int BIT_CAP = (DEFAULT_MAX_BITS > 63) ? 63 : DEFAULT_MAX_BITS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 40;
    localparam int RANDOM_PHASE_ITEMS = 20;

    typedef struct packed {
        logic [1:0] act;
        logic       lvl;
    } line_item_t;

    typedef struct packed {
        logic               tx_level;
        logic               tx_on;
        logic               ended;
        logic               forwarded;
        logic [COUNT_W-1:0] bits;
    } line_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   item_valid = 1'b0;
    logic                   item_ready;
    logic [1:0]             action = ACT_RX_TICK;
    logic                   line_level = 1'b0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    logic                   tx_line;
    logic                   tx_busy;
    logic                   frame_ended;
    logic                   frame_forwarded;
    logic [COUNT_W-1:0]     frame_bits;

    manchester_frame_repeat_filter #(
        .MAX_BITS(DEFAULT_MAX_BITS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .action(action),
        .line_level(line_level),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .tx_line(tx_line),
        .tx_busy(tx_busy),
        .frame_ended(frame_ended),
        .frame_forwarded(frame_forwarded),
        .frame_bits(frame_bits)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Shadow copy of the filter state and its registers.
    logic [TIMER_W-1:0] thr_cfg = HALF_BIT_THRESHOLD_RESET;
    logic [TIMER_W-1:0] tmo_cfg = FRAME_TIMEOUT_RESET;
    logic               rx_on = 1'b0;
    logic [TIMER_W-1:0] rx_ticks = '0;
    logic [FRAME_W-1:0] rx_frame = '0;
    logic [COUNT_W-1:0] rx_bits = '0;
    logic [FRAME_W-1:0] sent_frame = '0;
    logic [FRAME_W-1:0] tx_frame = '0;
    logic [COUNT_W-1:0] tx_left = '0;
    logic               tx_half = 1'b0;
    logic               tx_on = 1'b0;
    logic               tx_level = 1'b1;

    line_item_t   item_backlog[$];
    line_report_t awaited_reports[$];
    logic         prev_levels[$];

    int send_idle_max = 0;
    int recv_idle_max = 0;
    int send_wait = 0;
    int recv_wait = 0;
    int queued_count = 0;
    int result_count = 0;
    int mismatches = 0;
    int cycles = 0;

    function automatic line_report_t apply_item(input logic [1:0] act, input logic lvl);
        int           next_ticks;
        logic         bit_out;
        line_report_t rep;
        rep = '0;
        case (act)
            ACT_RX_TICK:
            begin
                if (rx_on)
                begin
                    next_ticks = int'(rx_ticks) + 1;
                    if (next_ticks >= int'(tmo_cfg))
                    begin
                        rx_on = 1'b0;
                        rx_ticks = '0;
                        rep.ended = 1'b1;
                        rep.bits = rx_bits;
                        if (rx_frame != sent_frame)
                        begin
                            sent_frame = rx_frame;
                            tx_frame = rx_frame;
                            tx_left = rx_bits;
                            tx_half = 1'b0;
                            tx_on = 1'b1;
                            rep.forwarded = 1'b1;
                        end
                    end
                    else
                    begin
                        rx_ticks = 8'(next_ticks);
                    end
                end
            end
            ACT_LINE_EDGE:
            begin
                if (!rx_on)
                begin
                    rx_on = 1'b1;
                    rx_ticks = '0;
                    rx_frame = '0;
                    rx_bits = '0;
                end
                else if (!(rx_bits > 0 && rx_ticks <= thr_cfg))
                begin
                    rx_ticks = '0;
                    rx_frame = {rx_frame[FRAME_W-2:0], lvl};
                    if (rx_bits < BIT_CAP)
                        rx_bits = rx_bits + 1'b1;
                end
            end
            ACT_TX_TICK:
            begin
                if (tx_on)
                begin
                    if (tx_left == 0)
                    begin
                        tx_level = 1'b0;
                        tx_on = 1'b0;
                    end
                    else
                    begin
                        bit_out = (tx_left > FRAME_W) ? 1'b0 : tx_frame[tx_left - 1];
                        if (!tx_half)
                        begin
                            tx_level = bit_out;
                            tx_half = 1'b1;
                        end
                        else
                        begin
                            tx_level = ~bit_out;
                            tx_half = 1'b0;
                            tx_left = tx_left - 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        rep.tx_level = tx_level;
        rep.tx_on = tx_on;
        return rep;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        if (mismatches < PRINT_LIMIT)
            $display("result %0d: %s is %0d, expected %0d", result_count, field, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Item driver.
    always @(posedge clk)
    begin
        line_item_t next_item;
        if (rst_n)
        begin
            if (item_valid && item_ready)
                awaited_reports.push_back(apply_item(action, line_level));
            if (!item_valid || item_ready)
            begin
                if (send_wait > 0)
                begin
                    item_valid <= 1'b0;
                    send_wait--;
                end
                else if (item_backlog.size() != 0)
                begin
                    next_item = item_backlog.pop_front();
                    item_valid <= 1'b1;
                    action <= next_item.act;
                    line_level <= next_item.lvl;
                    send_wait = $urandom_range(0, send_idle_max);
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        line_report_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (awaited_reports.size() == 0)
                begin
                    report_mismatch("unexpected result_valid", 1, 0);
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    if (tx_line !== want.tx_level)
                        report_mismatch("tx_line", tx_line, want.tx_level);
                    if (tx_busy !== want.tx_on)
                        report_mismatch("tx_busy", tx_busy, want.tx_on);
                    if (frame_ended !== want.ended)
                        report_mismatch("frame_ended", frame_ended, want.ended);
                    if (frame_forwarded !== want.forwarded)
                        report_mismatch("frame_forwarded", frame_forwarded, want.forwarded);
                    if (frame_bits !== want.bits)
                        report_mismatch("frame_bits", frame_bits, want.bits);
                end
                result_count++;
                recv_wait = $urandom_range(0, recv_idle_max);
            end
            if (recv_wait > 0)
            begin
                result_ready <= 1'b0;
                recv_wait--;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    task automatic queue_item(input logic [1:0] act, input logic lvl);
        line_item_t it;
        it.act = act;
        it.lvl = lvl;
        item_backlog.push_back(it);
        queued_count++;
    endtask

    task automatic maybe_tx_tick();
        if ($urandom_range(0, 2) == 0)
            queue_item(ACT_TX_TICK, 1'($urandom_range(0, 1)));
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (item_backlog.size() != 0 || item_valid || awaited_reports.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_HALF_BIT_THRESHOLD)
            thr_cfg = value;
        else if (idx == REG_FRAME_TIMEOUT)
            tmo_cfg = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input int thr, input int tmo, input int send_max,
                             input int recv_max);
        wait_drained();
        write_register(REG_HALF_BIT_THRESHOLD, 8'(thr));
        write_register(REG_FRAME_TIMEOUT, 8'(tmo));
        send_idle_max = send_max;
        recv_idle_max = recv_max;
    endtask

    // One frame on the receive line: a start edge, the bit edges spaced just
    // past the threshold with the odd early glitch, then ticks up to the timeout.
    task automatic queue_frame(input int thr, input int tmo);
        int   nbits;
        int   gap;
        logic lvls[$];
        if ($urandom_range(0, 2) == 0 && prev_levels.size() > 0)
        begin
            lvls = prev_levels;
        end
        else
        begin
            nbits = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40)
                                                : $urandom_range(0, 8);
            repeat (nbits)
                lvls.push_back(1'($urandom_range(0, 1)));
        end
        prev_levels = lvls;
        queue_item(ACT_LINE_EDGE, 1'($urandom_range(0, 1)));
        foreach (lvls[i])
        begin
            if (i > 0)
            begin
                gap = $urandom_range(thr + 1, thr + 2);
                if (gap >= tmo)
                    gap = (tmo > 0) ? tmo - 1 : 0;
                if ($urandom_range(0, 5) == 0)
                    queue_item(ACT_LINE_EDGE, 1'($urandom_range(0, 1)));
                repeat (gap)
                begin
                    queue_item(ACT_RX_TICK, 1'($urandom_range(0, 1)));
                    maybe_tx_tick();
                end
            end
            queue_item(ACT_LINE_EDGE, lvls[i]);
        end
        repeat ((tmo > 0 ? tmo : 1) + $urandom_range(0, 1))
        begin
            queue_item(ACT_RX_TICK, 1'($urandom_range(0, 1)));
            maybe_tx_tick();
        end
        repeat ($urandom_range(0, 2 * lvls.size() + 3))
            queue_item(ACT_TX_TICK, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int thr;
        int tmo;
        int phase_start;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        configure(1, 3, 2, 2);
        queue_item(ACT_UNUSED, 1'b1);
        queue_item(ACT_RX_TICK, 1'b0);
        queue_item(ACT_TX_TICK, 1'b1);
        queue_item(ACT_LINE_EDGE, 1'b1);
        queue_item(ACT_LINE_EDGE, 1'b1);
        queue_item(ACT_LINE_EDGE, 1'b0);
        repeat (2) queue_item(ACT_RX_TICK, 1'b0);
        queue_item(ACT_LINE_EDGE, 1'b0);
        repeat (3) queue_item(ACT_RX_TICK, 1'b1);
        repeat (2) queue_item(ACT_TX_TICK, 1'b0);
        // A new frame ends while the previous one is still being sent.
        queue_item(ACT_LINE_EDGE, 1'b0);
        queue_item(ACT_LINE_EDGE, 1'b1);
        repeat (3) queue_item(ACT_RX_TICK, 1'b0);
        repeat (3) queue_item(ACT_TX_TICK, 1'b1);
        // An empty frame differs from the last one and is forwarded.
        queue_item(ACT_LINE_EDGE, 1'b1);
        repeat (3) queue_item(ACT_RX_TICK, 1'b0);
        repeat (2) queue_item(ACT_TX_TICK, 1'b0);

        configure(0, 0, 4, 4);
        queue_item(ACT_LINE_EDGE, 1'b0);
        queue_item(ACT_RX_TICK, 1'b1);
        queue_item(ACT_LINE_EDGE, 1'b1);
        queue_item(ACT_LINE_EDGE, 1'b1);
        queue_item(ACT_RX_TICK, 1'b0);
        repeat (3) queue_item(ACT_TX_TICK, 1'b1);

        configure(255, 5, 1, 3);
        repeat (3) queue_frame(255, 5);

        configure(3, 255, 0, 4);
        queue_frame(3, 255);

        for (int phase = 0; phase < 4; phase++)
        begin
            thr = $urandom_range(0, 5);
            tmo = $urandom_range(1, 14);
            configure(thr, tmo, phase[0] ? 0 : 4, phase[1] ? 0 : 4);
            phase_start = queued_count;
            while (queued_count - phase_start < RANDOM_PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) == 0)
                    queue_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
                else
                    queue_frame(thr, tmo);
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
